>>> rtl/cou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_pkg
// Shared widths, register indexes and control structs of the cultural
// opinion update block.
// ----------------------------------------------------------------------------
package cou_pkg;

  localparam int DATA_W    = 32;  // packed feature vector
  localparam int COUNT_W   = 4;   // common_count
  localparam int RANK_W    = 4;   // pick_rank
  localparam int CNT_W     = 5;   // prefix count of differing features, up to 16
  localparam int IDX_W     = 4;   // feature index, up to 15
  localparam int OUT_IDX_W = 3;   // changed_index as delivered
  localparam int DRAW_W    = 16;  // random draws
  localparam int FIELD_W   = 17;  // field_strength register
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_FIELD_STRENGTH = 1'b0;

  // per-item control carried from the lane stage to the merge stage
  typedef struct packed {
    logic act_ok;   // accepted and common_count not equal to the feature count
    logic last_ok;  // last feature may be adopted
  } ctrl_t;

  typedef struct packed {
    logic                 changed;
    logic [OUT_IDX_W-1:0] changed_index;
    logic                 rank_error;
  } flags_t;

endpackage

>>> rtl/cou_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_lane
// One feature lane: flags whether the active and passive traits of its
// feature differ. Trait bits above bit 31 are treated as zero.
// ----------------------------------------------------------------------------
module cou_lane #(
  parameter int TRAIT_BITS = 4,
  parameter int LANE       = 0
) (
  input  logic [cou_pkg::DATA_W-1:0] act_i,
  input  logic [cou_pkg::DATA_W-1:0] pas_i,
  output logic                       diff_o
);
  import cou_pkg::*;

  localparam int Lo = LANE * TRAIT_BITS;

  logic [TRAIT_BITS-1:0] ne;

  for (genvar b = 0; b < TRAIT_BITS; b++) begin : g_bit
    if (Lo + b < DATA_W) begin : g_in
      assign ne[b] = act_i[Lo+b] ^ pas_i[Lo+b];
    end else begin : g_out
      assign ne[b] = 1'b0;
    end
  end

  assign diff_o = |ne;

endmodule

>>> rtl/cou_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_merge
// Combines the lane results: picks the pick_rank-th differing feature,
// applies the last-feature gate and builds the new active vector and flags.
// ----------------------------------------------------------------------------
module cou_merge #(
  parameter int FEATURES   = 8,
  parameter int TRAIT_BITS = 4
) (
  input  logic [cou_pkg::DATA_W-1:0] act_i,
  input  logic [cou_pkg::DATA_W-1:0] pas_i,
  input  logic [FEATURES-1:0]        diff_i,
  input  logic [cou_pkg::RANK_W-1:0] rank_i,
  input  cou_pkg::ctrl_t             ctrl_i,
  output logic [cou_pkg::DATA_W-1:0] new_vec_o,
  output cou_pkg::flags_t            flags_o
);
  import cou_pkg::*;

  logic [FEATURES-1:0] sel;
  logic [IDX_W-1:0]    idx;
  logic                found;
  logic                copy;
  logic [DATA_W-1:0]   new_vec;

  // each lane's prefix count is independent, so these compare in parallel
  for (genvar k = 0; k < FEATURES; k++) begin : g_sel
    logic [FEATURES-1:0] pre_mask;
    logic [CNT_W-1:0]    cnt;
    assign pre_mask = {FEATURES{1'b1}} >> (FEATURES - 1 - k);
    assign cnt      = CNT_W'($countones(diff_i & pre_mask));
    assign sel[k]   = diff_i[k] && (cnt == {1'b0, rank_i});
  end

  // sel is one-hot or zero
  always_comb begin
    idx = '0;
    for (int k = 0; k < FEATURES; k++) begin
      if (sel[k]) begin
        idx = idx | IDX_W'(k);
      end
    end
  end

  assign found = |sel;
  assign copy  = ctrl_i.act_ok && found && (!sel[FEATURES-1] || ctrl_i.last_ok);

  for (genvar p = 0; p < DATA_W; p++) begin : g_bit
    localparam int K = p / TRAIT_BITS;
    if (K < FEATURES) begin : g_feat
      assign new_vec[p] = (copy && sel[K]) ? pas_i[p] : act_i[p];
    end else begin : g_pad
      assign new_vec[p] = act_i[p];
    end
  end

  assign new_vec_o             = new_vec;
  assign flags_o.changed       = copy;
  assign flags_o.changed_index = (ctrl_i.act_ok && found) ? idx[OUT_IDX_W-1:0] : '0;
  assign flags_o.rank_error    = ctrl_i.act_ok && !found;

endmodule

>>> rtl/cultural_opinion_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cultural_opinion_update
// throughput: one transaction per cycle while m_axis_tready does not stall the output, set
//   by the two register stages (lane compare stage, merge and output stage)
// reset: rst_ni clears the stage valid flags and field_strength to zero
// One Axelrod-style interaction per item: acceptance test, selection of a
// differing feature across parallel lanes, and the copy into the active agent.
// ----------------------------------------------------------------------------
module cultural_opinion_update #(
  parameter int FEATURES   = 8,
  parameter int TRAIT_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata fields from bit 0 up: active_features[31:0], passive_features[63:32],
  // common_count[67:64], accept_draw[83:68], pick_rank[87:84], field_draw[103:88]
  input  logic [103:0]               s_axis_tdata,
  // tuser fields from bit 0 up: stubborn[0]
  input  logic                       s_axis_tuser,
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata fields from bit 0 up: new_active_features[31:0], changed_index[34:32],
  // zero fill[39:35]
  output logic [39:0]                m_axis_tdata,
  // tuser fields from bit 0 up: changed[0], rank_error[1]
  output logic [1:0]                 m_axis_tuser,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cou_pkg::APB_AW-1:0] paddr,
  input  logic [cou_pkg::APB_DW-1:0] pwdata,
  output logic [cou_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import cou_pkg::*;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] field_strength_q;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_FIELD_STRENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_strength_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      field_strength_q <= pwdata[FIELD_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(field_strength_q) : '0;

  // --------------------------------------------------------------------------
  // input field unpacking
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0]  in_act;
  logic [DATA_W-1:0]  in_pas;
  logic [COUNT_W-1:0] in_common;
  logic [DRAW_W-1:0]  in_adraw;
  logic [RANK_W-1:0]  in_rank;
  logic [DRAW_W-1:0]  in_fdraw;
  logic               in_stub;

  assign in_act    = s_axis_tdata[31:0];
  assign in_pas    = s_axis_tdata[63:32];
  assign in_common = s_axis_tdata[67:64];
  assign in_adraw  = s_axis_tdata[83:68];
  assign in_rank   = s_axis_tdata[87:84];
  assign in_fdraw  = s_axis_tdata[103:88];
  assign in_stub   = s_axis_tuser;

  // --------------------------------------------------------------------------
  // stage 1: lanes, acceptance test and last-feature gate
  // --------------------------------------------------------------------------
  logic [FEATURES-1:0] diff;
  logic [20:0]         acc_lhs;   // accept_draw * FEATURES, FEATURES up to 16
  logic [20:0]         acc_rhs;   // common_count * 65536
  logic [DRAW_W+1:0]   field_sum;
  ctrl_t               ctrl_d;

  for (genvar k = 0; k < FEATURES; k++) begin : g_lane
    cou_lane #(
      .TRAIT_BITS (TRAIT_BITS),
      .LANE       (k)
    ) u_lane (
      .act_i  (in_act),
      .pas_i  (in_pas),
      .diff_o (diff[k])
    );
  end

  assign acc_lhs   = 21'(in_adraw) * 21'(FEATURES);
  assign acc_rhs   = {1'b0, in_common, 16'h0000};
  assign field_sum = (DRAW_W+2)'(in_fdraw) + (DRAW_W+2)'(field_strength_q);

  // a count equal to the feature count accepts but changes nothing
  assign ctrl_d.act_ok  = (acc_lhs < acc_rhs) && ({1'b0, in_common} != 5'(FEATURES));
  assign ctrl_d.last_ok = !in_stub && (field_sum < (DRAW_W+2)'(18'h10000));

  logic                s1_valid_q;
  logic [DATA_W-1:0]   s1_act_q;
  logic [DATA_W-1:0]   s1_pas_q;
  logic [FEATURES-1:0] s1_diff_q;
  logic [RANK_W-1:0]   s1_rank_q;
  ctrl_t               s1_ctrl_q;
  logic                s1_ready;
  logic                s2_ready;

  // each stage takes a new transaction when empty or when its own is moving on
  assign s2_ready      = !m_axis_tvalid || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_act_q  <= in_act;
      s1_pas_q  <= in_pas;
      s1_diff_q <= diff;
      s1_rank_q <= in_rank;
      s1_ctrl_q <= ctrl_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: merge of lane results into the output register
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] new_vec;
  flags_t            flags;

  cou_merge #(
    .FEATURES   (FEATURES),
    .TRAIT_BITS (TRAIT_BITS)
  ) u_merge (
    .act_i     (s1_act_q),
    .pas_i     (s1_pas_q),
    .diff_i    (s1_diff_q),
    .rank_i    (s1_rank_q),
    .ctrl_i    (s1_ctrl_q),
    .new_vec_o (new_vec),
    .flags_o   (flags)
  );

  logic              out_valid_q;
  logic [DATA_W-1:0] out_vec_q;
  flags_t            out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_vec_q   <= new_vec;
      out_flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_flags_q.changed_index, out_vec_q};
  assign m_axis_tuser  = {out_flags_q.rank_error, out_flags_q.changed};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a copy and a rank error exclude each other
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_flags_q.changed && out_flags_q.rank_error))
    else $error("changed and rank_error both set");

  // a rank error names no feature
  a_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_flags_q.rank_error) |-> (out_flags_q.changed_index == '0))
    else $error("rank_error with nonzero changed_index");

  // a stage-1 transaction is not dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_act_q)))
    else $error("stage 1 lost a transaction under stall");

  // no copy unless the lane stage saw an accepted interaction
  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready && !s1_ctrl_q.act_ok) |=> !out_flags_q.changed)
    else $error("copy without accepted interaction");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cultural_opinion_update. A driver streams agent
// pairs from a queue, a bit-true predictor computes the expected interaction
// outcome of every accepted transaction, and a monitor compares each result
// against the oldest expectation. Runs several phases with different field
// strengths and different amounts of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FEATURES   = 8;
  localparam int TRAIT_BITS = 4;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 184;

  // register byte address, one 32-bit word per register
  localparam logic [cou_pkg::APB_AW-1:0] FIELD_ADDR = {cou_pkg::REG_FIELD_STRENGTH, 2'b00};

  // one agent pair as it goes into the block
  typedef struct {
    logic [31:0] active;
    logic [31:0] passive;
    logic [3:0]  common;
    logic        stubborn;
    logic [15:0] accept_draw;
    logic [3:0]  pick_rank;
    logic [15:0] field_draw;
  } pair_t;

  // outcome of one interaction
  typedef struct {
    logic [31:0] new_active;
    logic        changed;
    logic [2:0]  changed_index;
    logic        rank_error;
  } update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // stimulus side of the input stream
  logic         in_valid = 1'b0;
  logic [103:0] in_data  = '0;
  logic         in_user  = 1'b0;
  logic         in_ready;

  // output stream
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [39:0]  out_data;
  logic [1:0]   out_user;

  // configuration port
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [cou_pkg::APB_AW-1:0]  paddr   = '0;
  logic [cou_pkg::APB_DW-1:0]  pwdata  = '0;
  logic [cou_pkg::APB_DW-1:0]  prdata;
  logic                        pready;

  // predictor copy of the field strength register
  logic [cou_pkg::FIELD_W-1:0] field_strength_q = '0;

  pair_t   pairs_to_send[$];
  update_t expected_updates[$];
  pair_t   pair_in_flight;
  update_t want;
  update_t got;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatch_cnt    = 0;

  always #5 clk_i = ~clk_i;

  cultural_opinion_update #(
    .FEATURES  (FEATURES),
    .TRAIT_BITS(TRAIT_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_user),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_data),
    .m_axis_tuser (out_user),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // bit-true outcome of one interaction under the current field strength
  function automatic update_t predict_interaction(pair_t p);
    update_t     u;
    int unsigned cnt;
    int unsigned idx;
    int          k;
    bit          found;
    bit          accept;
    bit          copy_ok;
    u.new_active = p.active;
    u.changed    = 1'b0;
    u.rank_error = 1'b0;
    idx   = 0;
    cnt   = 0;
    found = 1'b0;
    // similarity-proportional acceptance in 16-bit fixed point
    accept = (32'(p.accept_draw) * FEATURES) < (32'(p.common) << 16);
    // a count equal to the feature count means identical agents, nothing to do
    if (accept && p.common != FEATURES) begin
      for (k = 0; k < FEATURES; k++) begin
        if (p.active[k*TRAIT_BITS +: TRAIT_BITS] != p.passive[k*TRAIT_BITS +: TRAIT_BITS]) begin
          cnt++;
          if (cnt == p.pick_rank && !found) begin
            found = 1'b1;
            idx   = k;
          end
        end
      end
      if (!found) begin
        // rank of zero or past the differing features
        u.rank_error = 1'b1;
        idx = 0;
      end else begin
        // the last feature obeys stubbornness and the external field
        copy_ok = (idx != FEATURES - 1) ||
                  (!p.stubborn && (32'(p.field_draw) + 32'(field_strength_q) < 32'h10000));
        if (copy_ok) begin
          u.new_active[idx*TRAIT_BITS +: TRAIT_BITS] = p.passive[idx*TRAIT_BITS +: TRAIT_BITS];
          u.changed = 1'b1;
        end
      end
    end
    u.changed_index = 3'(idx);
    return u;
  endfunction

  function automatic pair_t build_pair(logic [31:0] act, logic [31:0] pas, logic [3:0] common,
                                       logic stub, logic [15:0] adraw, logic [3:0] rank,
                                       logic [15:0] fdraw);
    pair_t p;
    p.active      = act;
    p.passive     = pas;
    p.common      = common;
    p.stubborn    = stub;
    p.accept_draw = adraw;
    p.pick_rank   = rank;
    p.field_draw  = fdraw;
    return p;
  endfunction

  // register write with a setup and an access phase, only called while the block is idle
  task automatic apb_write(logic [cou_pkg::APB_AW-1:0] addr, logic [cou_pkg::APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    field_strength_q = data[cou_pkg::FIELD_W-1:0];
  endtask

  // mostly consistent pairs (true common count, rank within the differing
  // features), the rest noise with arbitrary counts and ranks
  task automatic queue_random_pairs(int n);
    pair_t p;
    int    ndiff;
    int    k;
    int    limit;
    repeat (n) begin
      p.active  = $urandom();
      p.passive = p.active;
      for (k = 0; k < FEATURES; k++) begin
        if ($urandom_range(1) == 1) begin
          p.passive[k*TRAIT_BITS +: TRAIT_BITS] = TRAIT_BITS'($urandom_range(15));
        end
      end
      if ($urandom_range(5) == 0) p.passive = $urandom();
      // push the last feature into play often
      if ($urandom_range(2) == 0) begin
        p.passive[31:28] = ~p.active[31:28];
      end
      ndiff = 0;
      for (k = 0; k < FEATURES; k++) begin
        if (p.active[k*TRAIT_BITS +: TRAIT_BITS] != p.passive[k*TRAIT_BITS +: TRAIT_BITS]) ndiff++;
      end
      p.common      = ($urandom_range(4) != 0) ? 4'(FEATURES - ndiff) : 4'($urandom_range(15));
      p.stubborn    = 1'($urandom_range(1));
      p.accept_draw = 16'($urandom_range(65535));
      if (ndiff > 0 && $urandom_range(4) != 0) p.pick_rank = 4'($urandom_range(ndiff, 1));
      else p.pick_rank = 4'($urandom_range(15));
      // sometimes sit right on the field threshold
      limit = 65536 - int'(field_strength_q);
      p.field_draw = 16'($urandom_range(65535));
      if ($urandom_range(3) == 0 && limit > 0) begin
        if ($urandom_range(1) == 0 || limit > 65535) p.field_draw = 16'(limit - 1);
        else p.field_draw = 16'(limit);
      end
      pairs_to_send.push_back(p);
    end
  endtask

  // driver: hold the transaction until it is taken, then load the next one
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      expected_updates.push_back(predict_interaction(pair_in_flight));
    end
    if (!in_valid || in_ready) begin
      if (rst_ni && pairs_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        pair_in_flight = pairs_to_send.pop_front();
        in_data  <= {pair_in_flight.field_draw, pair_in_flight.pick_rank,
                     pair_in_flight.accept_draw, pair_in_flight.common,
                     pair_in_flight.passive, pair_in_flight.active};
        in_user  <= pair_in_flight.stubborn;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check every accepted result, then choose the next ready
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      got.new_active    = out_data[31:0];
      got.changed_index = out_data[34:32];
      got.changed       = out_user[0];
      got.rank_error    = out_user[1];
      if (expected_updates.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("%0t: unexpected result active=%h changed=%b index=%0d rank_error=%b", $realtime,
                   got.new_active, got.changed, got.changed_index, got.rank_error);
        end
        mismatch_cnt++;
      end else begin
        want = expected_updates.pop_front();
        if (got.new_active !== want.new_active || got.changed !== want.changed ||
            got.changed_index !== want.changed_index || got.rank_error !== want.rank_error) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: mismatch active exp=%h got=%h changed exp=%b got=%b", $realtime,
                     want.new_active, got.new_active, want.changed, got.changed);
            $display("           index exp=%0d got=%0d rank_error exp=%b got=%b",
                     want.changed_index, got.changed_index, want.rank_error, got.rank_error);
          end
          mismatch_cnt++;
        end
      end
    end
    out_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // phase plan: field strength and idling per phase
  int unsigned phase_fs[PHASES]        = '{0, 65536, 32768, 0, 65535, 1};
  int unsigned phase_src_idle[PHASES]  = '{0, 55, 0, 21, 0, 21};
  int unsigned phase_sink_stall[PHASES] = '{0, 0, 55, 21, 0, 21};

  initial begin
    int ph;
    logic [31:0] a;
    a = 32'h7654_3210;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = phase_src_idle[ph];
      recv_stall_pct  = phase_sink_stall[ph];
      // first phase runs on the reset value of the register
      if (ph != 0) begin
        if (ph == 3) apb_write(FIELD_ADDR, $urandom_range(65536));
        else apb_write(FIELD_ADDR, phase_fs[ph]);
      end
      if (ph == 0) begin
        // never accepted: zero count, with zero draw and with top draw
        pairs_to_send.push_back(build_pair('0, '0, 4'd0, 1'b0, 16'h0000, 4'd1, 16'h0000));
        pairs_to_send.push_back(build_pair('0, '1, 4'd0, 1'b1, 16'hffff, 4'd1, 16'h0000));
        // largest count and rank, all features differ
        pairs_to_send.push_back(build_pair('1, '0, 4'd15, 1'b1, 16'hffff, 4'd15, 16'hffff));
        // full count always accepts but changes nothing
        pairs_to_send.push_back(build_pair(a, ~a, 4'd8, 1'b0, 16'hffff, 4'd1, 16'h0000));
        // single differing feature: hit, rank zero, rank too large
        pairs_to_send.push_back(build_pair(a, a ^ 32'h10, 4'd7, 1'b0, 16'h0000, 4'd1, 16'h0000));
        pairs_to_send.push_back(build_pair(a, a ^ 32'h10, 4'd7, 1'b0, 16'h0000, 4'd0, 16'h0000));
        pairs_to_send.push_back(build_pair(a, a ^ 32'h10, 4'd7, 1'b0, 16'h0000, 4'd2, 16'h0000));
        // acceptance threshold for a count of one
        pairs_to_send.push_back(build_pair(a, ~a, 4'd1, 1'b0, 16'd8191, 4'd3, 16'h0000));
        pairs_to_send.push_back(build_pair(a, ~a, 4'd1, 1'b0, 16'd8192, 4'd3, 16'h0000));
        // acceptance threshold for a count of four
        pairs_to_send.push_back(build_pair('1, '0, 4'd4, 1'b0, 16'h7fff, 4'd4, 16'h0000));
        pairs_to_send.push_back(build_pair('1, '0, 4'd4, 1'b0, 16'h8000, 4'd4, 16'h0000));
        // last feature: adopted at the top draw, blocked when stubborn
        pairs_to_send.push_back(build_pair(a, a ^ 32'hf000_0000, 4'd7, 1'b0, 16'h0, 4'd1, 16'hffff));
        pairs_to_send.push_back(build_pair(a, a ^ 32'hf000_0000, 4'd7, 1'b1, 16'h0, 4'd1, 16'h0000));
        pairs_to_send.push_back(build_pair(a, ~a, 4'd0, 1'b0, 16'h0, 4'd8, 16'h0000));
        pairs_to_send.push_back(build_pair(a, ~a, 4'd9, 1'b1, 16'hffff, 4'd8, 16'h0000));
        // identical agents with a wrong count: accepted, nothing to pick
        pairs_to_send.push_back(build_pair(a, a, 4'd7, 1'b0, 16'h0000, 4'd1, 16'h0000));
        // counts above the feature count always accept
        pairs_to_send.push_back(build_pair('0, '1, 4'd9, 1'b0, 16'hffff, 4'd5, 16'h0000));
        pairs_to_send.push_back(build_pair('1, a, 4'd15, 1'b0, 16'h1234, 4'd2, 16'h0000));
      end
      queue_random_pairs(PHASE_ITEMS);
      // drain before the next register write
      while (pairs_to_send.size() != 0 || in_valid || expected_updates.size() != 0) begin
        @(negedge clk_i);
      end
    end
    // every transaction has a result, a short settle covers the pipeline
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> cultural_opinion_update.f
rtl/cou_pkg.sv
rtl/cou_lane.sv
rtl/cou_merge.sv
rtl/cultural_opinion_update.sv
test/tb_top.sv
